@@ hdl/rvl_pkg.sv @@
`default_nettype none

package rvl_pkg;

  // Default sizes
  localparam int unsigned DefMaxVoters    = 256;
  localparam int unsigned DefHistoryDepth = 1024;

  // Result status codes
  typedef enum logic [2:0] {
    ST_VOTE_OK  = 3'd0,
    ST_QUERY_OK = 3'd1,
    ST_EMPTY    = 3'd2,
    ST_FULL     = 3'd3,
    ST_ORDER    = 3'd4
  } status_e;

  // Request kinds
  typedef enum logic {
    KIND_VOTE  = 1'b0,
    KIND_QUERY = 1'b1
  } kind_e;

  // Sequencer states
  typedef enum logic [2:0] {
    S_IDLE,
    S_CHECK,
    S_CREAD,
    S_CUPD,
    S_QMID,
    S_QCMP,
    S_QFIN,
    S_RESP
  } state_e;

  typedef struct packed {
    logic        kind;
    logic [7:0]  voter_id;
    logic [31:0] vote_time;
    logic [31:0] query_time;
  } req_t;

  typedef struct packed {
    logic [7:0] leader_id;
    status_e    status;
  } rsp_t;

  // One history entry: time of the vote and leader after it
  typedef struct packed {
    logic [31:0] stamp;
    logic [7:0]  leader;
  } hist_entry_t;

endpackage

`default_nettype wire

@@ hdl/rvl_hist.sv @@
`default_nettype none

module rvl_hist #(
  parameter int unsigned HISTORY_DEPTH = rvl_pkg::DefHistoryDepth,
  localparam int unsigned AW = $clog2(HISTORY_DEPTH)
) (
  input  wire                  clk_i,
  input  wire                  we_i,
  input  wire [AW-1:0]         waddr_i,
  input  rvl_pkg::hist_entry_t wdata_i,
  input  wire [AW-1:0]         raddr_i,
  output rvl_pkg::hist_entry_t rdata_o
);

  rvl_pkg::hist_entry_t mem [HISTORY_DEPTH];
  rvl_pkg::hist_entry_t rdata_q;

  // Write one entry, read one entry with registered data
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_q <= mem[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

@@ hdl/running_vote_leader_with_time_query.sv @@
`default_nettype none

// Election tracker with a time-indexed leader history. Each request is a vote
// (count one for voter_id, record the vote time and resulting leader) or a
// query (leader in force at query_time, or the first recorded leader if
// query_time is before every vote, found by binary search over the history).
// The block handles one request at a time and drops req_ready_o while
// working; results sit in an output register, so the next request is taken
// while a result still waits. A vote goes through check, count read, count
// update and result load; a dropped vote or an empty-history query goes
// through check and result load. A query runs check, search probes, a final
// leader read and result load; each probe is a registered history read and
// then a compare in the shared 32-bit compare unit. A finished result waits
// while the output register still holds an unaccepted one, and the block is
// ready again in the cycle after the result loads.
// Vote counts clear at reset through per-entry valid bits; no clearing pass.
module running_vote_leader_with_time_query #(
  parameter int unsigned MAX_VOTERS    = rvl_pkg::DefMaxVoters,
  parameter int unsigned HISTORY_DEPTH = rvl_pkg::DefHistoryDepth
) (
  input  wire           clk_i,
  input  wire           rst_ni,
  input  wire           req_valid_i,
  output logic          req_ready_o,
  input  rvl_pkg::req_t req_i,
  output logic          rsp_valid_o,
  input  wire           rsp_ready_i,
  output rvl_pkg::rsp_t rsp_o
);

  localparam int unsigned CntDepth = (MAX_VOTERS < 256) ? MAX_VOTERS : 256;
  localparam int unsigned SlotW    = $clog2(CntDepth);
  localparam int unsigned CntW     = $clog2(HISTORY_DEPTH + 1);
  localparam int unsigned AW       = $clog2(HISTORY_DEPTH);
  localparam logic [16:0] ModRecip = 17'(65536 / CntDepth + 1);

  // Reduce an id modulo the voter count by reciprocal multiplication
  function automatic logic [7:0] id_mod(input logic [7:0] id);
    logic [23:0] prod;
    logic [7:0]  quo;
    logic [15:0] back;
    prod = {16'd0, id} * {7'd0, ModRecip};
    quo  = prod[23:16];
    back = {8'd0, quo} * 16'(CntDepth);
    return id - back[7:0];
  endfunction

  rvl_pkg::state_e state_q, state_d;
  rvl_pkg::req_t   req_q;
  rvl_pkg::rsp_t   res_q, res_d;
  rvl_pkg::rsp_t   rsp_q;
  logic            rsp_valid_q, rsp_valid_d;

  logic [SlotW-1:0] slot_q, slot_d;
  logic [CntW-1:0]  entry_cnt_q, entry_cnt_d;
  logic [7:0]       leader_q, leader_d;
  logic [CntW-1:0]  leader_votes_q, leader_votes_d;
  logic [31:0]      newest_q, newest_d;
  logic [AW-1:0]    lo_q, lo_d, hi_q, hi_d, mid_q, mid_d;

  // Vote count store with reset-cleared valid bits
  logic [CntW-1:0]     cnt_mem [CntDepth];
  logic [CntW-1:0]     cnt_rd_q;
  logic [CntDepth-1:0] cnt_vld_q;
  logic                cnt_we;
  logic [CntW-1:0]     cnt_cur, cnt_new;

  // History port
  logic                 hist_we;
  logic [AW-1:0]        hist_raddr;
  rvl_pkg::hist_entry_t hist_wdata, hist_rdata;

  // Shared compare unit
  logic [31:0] cmp_a, cmp_b;
  logic        cmp_le;
  logic [AW:0] mid_sum;
  logic [AW-1:0] mid_c;

  assign cmp_le  = (cmp_a <= cmp_b);
  assign mid_sum = {1'b0, lo_q} + {1'b0, hi_q} + (AW+1)'(1);
  assign mid_c   = mid_sum[AW:1];
  assign cnt_cur = cnt_vld_q[slot_q] ? cnt_rd_q : '0;
  assign cnt_new = cnt_cur + CntW'(1);

  rvl_hist #(
    .HISTORY_DEPTH(HISTORY_DEPTH)
  ) u_hist (
    .clk_i  (clk_i),
    .we_i   (hist_we),
    .waddr_i(entry_cnt_q[AW-1:0]),
    .wdata_i(hist_wdata),
    .raddr_i(hist_raddr),
    .rdata_o(hist_rdata)
  );

  // Hold the count memory: write on update, read at the latched slot
  always_ff @(posedge clk_i) begin
    if (cnt_we) begin
      cnt_mem[slot_q] <= cnt_new;
    end
    cnt_rd_q <= cnt_mem[slot_q];
  end

  // Mark counts as written
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_vld_q <= '0;
    end else if (cnt_we) begin
      cnt_vld_q[slot_q] <= 1'b1;
    end
  end

  // Control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q        <= rvl_pkg::S_IDLE;
      rsp_valid_q    <= 1'b0;
      entry_cnt_q    <= '0;
      leader_q       <= '0;
      leader_votes_q <= '0;
      newest_q       <= '0;
    end else begin
      state_q        <= state_d;
      rsp_valid_q    <= rsp_valid_d;
      entry_cnt_q    <= entry_cnt_d;
      leader_q       <= leader_d;
      leader_votes_q <= leader_votes_d;
      newest_q       <= newest_d;
    end
  end

  // Payload and search registers
  always_ff @(posedge clk_i) begin
    if (req_valid_i && req_ready_o) begin
      req_q <= req_i;
    end
    if (state_q == rvl_pkg::S_RESP && (!rsp_valid_q || rsp_ready_i)) begin
      rsp_q <= res_q;
    end
    res_q  <= res_d;
    slot_q <= slot_d;
    lo_q   <= lo_d;
    hi_q   <= hi_d;
    mid_q  <= mid_d;
  end

  // Sequence one request
  always_comb begin
    state_d        = state_q;
    res_d          = res_q;
    slot_d         = slot_q;
    lo_d           = lo_q;
    hi_d           = hi_q;
    mid_d          = mid_q;
    entry_cnt_d    = entry_cnt_q;
    leader_d       = leader_q;
    leader_votes_d = leader_votes_q;
    newest_d       = newest_q;
    rsp_valid_d    = rsp_valid_q && !rsp_ready_i;
    cnt_we         = 1'b0;
    hist_we        = 1'b0;
    hist_raddr     = hi_q;
    hist_wdata     = '{stamp: req_q.vote_time, leader: leader_q};
    cmp_a          = req_q.vote_time;
    cmp_b          = newest_q;
    req_ready_o    = 1'b0;

    case (state_q)
      rvl_pkg::S_IDLE: begin
        req_ready_o = 1'b1;
        if (req_valid_i) begin
          state_d = rvl_pkg::S_CHECK;
        end
      end

      // Classify the request and reduce the id to a slot
      rvl_pkg::S_CHECK: begin
        if (MAX_VOTERS >= 256) begin
          slot_d = SlotW'(req_q.voter_id);
        end else begin
          slot_d = SlotW'(id_mod(req_q.voter_id));
        end
        lo_d = '0;
        hi_d = AW'(entry_cnt_q - CntW'(1));
        if (req_q.kind == rvl_pkg::KIND_VOTE) begin
          if (entry_cnt_q >= CntW'(HISTORY_DEPTH)) begin
            res_d   = '{leader_id: leader_q, status: rvl_pkg::ST_FULL};
            state_d = rvl_pkg::S_RESP;
          end else if (entry_cnt_q != '0 && cmp_le) begin
            res_d   = '{leader_id: leader_q, status: rvl_pkg::ST_ORDER};
            state_d = rvl_pkg::S_RESP;
          end else begin
            state_d = rvl_pkg::S_CREAD;
          end
        end else if (entry_cnt_q == '0) begin
          res_d   = '{leader_id: 8'd0, status: rvl_pkg::ST_EMPTY};
          state_d = rvl_pkg::S_RESP;
        end else begin
          state_d = rvl_pkg::S_QMID;
        end
      end

      // Wait for the count read
      rvl_pkg::S_CREAD: begin
        state_d = rvl_pkg::S_CUPD;
      end

      // Bump the count, elect, append to history
      rvl_pkg::S_CUPD: begin
        cnt_we = 1'b1;
        if (cnt_new >= leader_votes_q) begin
          leader_d       = req_q.voter_id;
          leader_votes_d = cnt_new;
        end
        hist_we     = 1'b1;
        hist_wdata  = '{stamp: req_q.vote_time, leader: leader_d};
        entry_cnt_d = entry_cnt_q + CntW'(1);
        newest_d    = req_q.vote_time;
        res_d       = '{leader_id: leader_d, status: rvl_pkg::ST_VOTE_OK};
        state_d     = rvl_pkg::S_RESP;
      end

      // Issue a probe, or the final leader read
      rvl_pkg::S_QMID: begin
        if (lo_q < hi_q) begin
          hist_raddr = mid_c;
          mid_d      = mid_c;
          state_d    = rvl_pkg::S_QCMP;
        end else begin
          hist_raddr = hi_q;
          state_d    = rvl_pkg::S_QFIN;
        end
      end

      // Narrow the search window
      rvl_pkg::S_QCMP: begin
        cmp_a = hist_rdata.stamp;
        cmp_b = req_q.query_time;
        if (cmp_le) begin
          lo_d = mid_q;
        end else begin
          hi_d = mid_q - AW'(1);
        end
        state_d = rvl_pkg::S_QMID;
      end

      rvl_pkg::S_QFIN: begin
        res_d   = '{leader_id: hist_rdata.leader, status: rvl_pkg::ST_QUERY_OK};
        state_d = rvl_pkg::S_RESP;
      end

      // Load the output register once it is free
      rvl_pkg::S_RESP: begin
        if (!rsp_valid_q || rsp_ready_i) begin
          rsp_valid_d = 1'b1;
          state_d     = rvl_pkg::S_IDLE;
        end
      end

      default: begin
        state_d = rvl_pkg::S_IDLE;
      end
    endcase
  end

  assign rsp_valid_o = rsp_valid_q;
  assign rsp_o       = rsp_q;

endmodule

`default_nettype wire

@@ dv/tb_top.sv @@
`timescale 1ns / 100ps

module tb_top;
  import rvl_pkg::*;

  localparam int unsigned Voters     = DefMaxVoters;
  localparam int unsigned Depth      = DefHistoryDepth;
  localparam int unsigned PhaseItems = 610;
  localparam int unsigned HoldOff    = 300;
  localparam int unsigned DrainWait  = 60;
  localparam int unsigned CycleLimit = 1_000_000;

  // Election tracker mirror: predicts each result and checks what comes back
  class election_tracker;
    logic [10:0] tally [Voters];
    logic [31:0] stamp_log [Depth];
    logic [7:0]  leader_log [Depth];
    int unsigned logged;
    logic [7:0]  leader;
    logic [10:0] leader_tally;
    logic [31:0] latest_stamp;
    rsp_t        expected_rsp [$];
    int unsigned mismatches;

    function new();
      foreach (tally[i]) tally[i] = '0;
      logged       = 0;
      leader       = '0;
      leader_tally = '0;
      latest_stamp = '0;
      mismatches   = 0;
    endfunction

    // Find the leader of the last entry stamped at or before t, else of the first one
    function logic [7:0] leader_at(logic [31:0] t);
      int unsigned lo;
      int unsigned hi;
      int unsigned mid;
      lo = 0;
      hi = logged - 1;
      while (lo < hi) begin
        mid = (lo + hi + 1) / 2;
        if (stamp_log[mid] <= t) lo = mid;
        else hi = mid - 1;
      end
      return leader_log[hi];
    endfunction

    // Apply an accepted request and queue the result it should produce
    function void note_request(req_t r);
      rsp_t        exp_rsp;
      int unsigned slot;
      logic [10:0] count;
      if (kind_e'(r.kind) == KIND_VOTE) begin
        if (logged >= Depth) begin
          exp_rsp.leader_id = leader;
          exp_rsp.status    = ST_FULL;
        end else if (logged != 0 && r.vote_time <= latest_stamp) begin
          exp_rsp.leader_id = leader;
          exp_rsp.status    = ST_ORDER;
        end else begin
          slot        = int'(r.voter_id) % Voters;
          count       = tally[slot] + 11'd1;
          tally[slot] = count;
          if (count >= leader_tally) begin
            leader       = r.voter_id;
            leader_tally = count;
          end
          stamp_log[logged]  = r.vote_time;
          leader_log[logged] = leader;
          logged++;
          latest_stamp      = r.vote_time;
          exp_rsp.leader_id = leader;
          exp_rsp.status    = ST_VOTE_OK;
        end
      end else if (logged == 0) begin
        exp_rsp.leader_id = '0;
        exp_rsp.status    = ST_EMPTY;
      end else begin
        exp_rsp.leader_id = leader_at(r.query_time);
        exp_rsp.status    = ST_QUERY_OK;
      end
      expected_rsp.push_back(exp_rsp);
    endfunction

    // Compare a delivered result with the oldest expectation
    function void check_result(rsp_t got);
      rsp_t exp_rsp;
      if (expected_rsp.size() == 0) begin
        $display("%0t: unexpected result leader %0d status %0d", $time,
                 got.leader_id, got.status);
        mismatches++;
        return;
      end
      exp_rsp = expected_rsp.pop_front();
      if (got.leader_id !== exp_rsp.leader_id) begin
        $display("%0t: leader_id expected %0d got %0d", $time,
                 exp_rsp.leader_id, got.leader_id);
        mismatches++;
      end
      if (got.status !== exp_rsp.status) begin
        $display("%0t: status expected %0d got %0d", $time,
                 exp_rsp.status, got.status);
        mismatches++;
      end
    endfunction
  endclass

  logic clk_i = 1'b0;
  logic rst_ni;
  logic req_valid_i;
  logic req_ready_o;
  req_t req_i;
  logic rsp_valid_o;
  logic rsp_ready_i;
  rsp_t rsp_o;

  election_tracker board = new();
  int unsigned     send_idle_pct;
  int unsigned     rsp_idle_pct;
  bit              hold_off_req;
  int unsigned     cycle_count;

  running_vote_leader_with_time_query dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .req_valid_i(req_valid_i),
    .req_ready_o(req_ready_o),
    .req_i      (req_i),
    .rsp_valid_o(rsp_valid_o),
    .rsp_ready_i(rsp_ready_i),
    .rsp_o      (rsp_o)
  );

  always #6 clk_i = ~clk_i;

  // Count cycles and stop a hung run
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
  end

  initial begin
    cycle_count = 0;
    wait (cycle_count >= CycleLimit);
    $display("%0t: timeout after %0d cycles", $time, cycle_count);
    $display("CHECKS FAILED");
    $finish;
  end

  // Check every delivered result
  always @(posedge clk_i) begin
    if (rst_ni && rsp_valid_o && rsp_ready_i) board.check_result(rsp_o);
  end

  // Drive result ready: random stalls, plus one long hold-off on request
  initial begin
    rsp_ready_i = 1'b0;
    wait (rst_ni === 1'b1);
    forever begin
      @(negedge clk_i);
      if (hold_off_req) begin
        hold_off_req = 1'b0;
        rsp_ready_i <= 1'b0;
        repeat (HoldOff) @(negedge clk_i);
      end else begin
        rsp_ready_i <= ($urandom_range(0, 99) >= rsp_idle_pct);
      end
    end
  end

  function automatic req_t vote_req(logic [7:0] id, logic [31:0] t);
    req_t r;
    r.kind       = KIND_VOTE;
    r.voter_id   = id;
    r.vote_time  = t;
    r.query_time = $urandom();
    return r;
  endfunction

  function automatic req_t query_req(logic [31:0] t);
    req_t r;
    r.kind       = KIND_QUERY;
    r.voter_id   = $urandom_range(0, 255);
    r.vote_time  = $urandom();
    r.query_time = t;
    return r;
  endfunction

  // Build a random request, mostly in-order votes that walk the time range
  function automatic req_t random_request();
    logic [7:0]      id;
    logic [31:0]     t;
    longint unsigned budget;
    longint unsigned span;
    int unsigned     idx;
    if ($urandom_range(0, 99) < 70) begin
      id = $urandom_range(0, 1) ? 8'($urandom_range(0, 7)) : 8'($urandom_range(0, 255));
      if (board.logged >= Depth) begin
        t = $urandom();
      end else if (board.logged != 0 && $urandom_range(0, 99) < 10) begin
        // stale time: equal to or below the newest stamp
        t = $urandom_range(0, 1) ? board.latest_stamp : $urandom_range(0, board.latest_stamp);
      end else if (board.logged == Depth - 1) begin
        t = 32'hFFFF_FFFF;
      end else begin
        budget = 64'hFFFF_FFFF - board.latest_stamp;
        span   = budget / (Depth - board.logged);
        t      = board.latest_stamp +
                 ((span <= 1) ? 32'd1 : 32'($urandom_range(1, 32'(2 * span - 1))));
      end
      return vote_req(id, t);
    end
    if (board.logged == 0 || $urandom_range(0, 99) < 40) return query_req($urandom());
    idx = $urandom_range(0, board.logged - 1);
    case ($urandom_range(0, 2))
      0:       t = board.stamp_log[idx] - 32'd1;
      1:       t = board.stamp_log[idx] + 32'd1;
      default: t = board.stamp_log[idx];
    endcase
    return query_req(t);
  endfunction

  // Offer one request after random idle cycles and hold it until taken
  task automatic offer_request(input req_t r);
    @(negedge clk_i);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      req_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    req_valid_i <= 1'b1;
    req_i       <= r;
    do @(posedge clk_i); while (!req_ready_o);
    board.note_request(r);
  endtask

  task automatic run_random(input int unsigned count);
    repeat (count) offer_request(random_request());
  endtask

  initial begin
    rst_ni        = 1'b0;
    req_valid_i   = 1'b0;
    req_i         = '0;
    hold_off_req  = 1'b0;
    send_idle_pct = 11;
    rsp_idle_pct  = 83;
    repeat (8) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // Query an empty history
    offer_request(query_req(32'd0));
    offer_request(query_req(32'hFFFF_FFFF));
    // First vote, then ask before it and at it
    offer_request(vote_req(8'd5, 32'd100));
    offer_request(query_req(32'd0));
    offer_request(query_req(32'd99));
    offer_request(query_req(32'd100));
    // Tie goes to the latest voter
    offer_request(vote_req(8'd255, 32'd200));
    // Drop votes with a repeated or older time
    offer_request(vote_req(8'd0, 32'd200));
    offer_request(vote_req(8'd0, 32'd0));
    offer_request(vote_req(8'd5, 32'd300));
    offer_request(vote_req(8'd0, 32'd400));
    offer_request(vote_req(8'd0, 32'd500));
    // Look up across the changes of leader
    offer_request(query_req(32'd199));
    offer_request(query_req(32'd250));
    offer_request(query_req(32'd450));
    offer_request(query_req(32'd500));
    offer_request(query_req(32'hFFFF_FFFF));

    run_random(PhaseItems);
    send_idle_pct = 83;
    rsp_idle_pct  = 11;
    run_random(PhaseItems);
    send_idle_pct = 0;
    rsp_idle_pct  = 0;
    // Stall results for a long stretch while requests keep coming
    hold_off_req = 1'b1;
    run_random(PhaseItems);

    @(negedge clk_i);
    req_valid_i <= 1'b0;
    while (board.expected_rsp.size() != 0) @(posedge clk_i);
    repeat (DrainWait) @(posedge clk_i);

    if (board.expected_rsp.size() != 0) begin
      $display("%0t: %0d results never arrived", $time, board.expected_rsp.size());
      board.mismatches++;
    end
    if (board.mismatches == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
